FILE: sv/tmef_pkg.sv
package tmef_pkg;

    // field widths
    localparam int TEMP_W     = 12;
    localparam int ALPHA_W    = 16;
    localparam int OUT_W      = 20;
    localparam int CAUSE_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // mean is carried with 8 extra fraction bits (quarter degree -> 1/1024 degree)
    localparam int FRAC_BITS  = 8;
    // counter width for the serial alpha multiply
    localparam int MCNT_W     = 4;

    localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EMA_ALPHA = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIP_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIP_HIGH = 2'd2;

    // configuration reset values
    localparam logic [ALPHA_W-1:0] EMA_ALPHA_RST = 16'd26214;
    localparam logic [TEMP_W-1:0]  TRIP_LOW_RST  = 12'd0;
    localparam logic [TEMP_W-1:0]  TRIP_HIGH_RST = 12'd4000;

    // shutoff causes
    localparam logic [CAUSE_W-1:0] CAUSE_NONE  = 2'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_FAULT = 2'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_LOW   = 2'd2;
    localparam logic [CAUSE_W-1:0] CAUSE_HIGH  = 2'd3;

endpackage

FILE: sv/tmef_if.sv
interface tmef_in_if;
    logic                        valid;
    logic                        ready;
    logic [tmef_pkg::TEMP_W-1:0] temp_sample;
    logic                        sensor_fault;

    modport source (output valid, output temp_sample, output sensor_fault, input ready);
    modport sink   (input valid, input temp_sample, input sensor_fault, output ready);
endinterface

interface tmef_out_if;
    logic                         valid;
    logic                         ready;
    logic [tmef_pkg::OUT_W-1:0]   mean_temp;
    logic [tmef_pkg::OUT_W-1:0]   filtered_temp;
    logic                         shutoff;
    logic [tmef_pkg::CAUSE_W-1:0] shutoff_cause;

    modport source (output valid, output mean_temp, output filtered_temp,
                    output shutoff, output shutoff_cause, input ready);
    modport sink   (input valid, input mean_temp, input filtered_temp,
                    input shutoff, input shutoff_cause, output ready);
endinterface

interface tmef_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tmef_pkg::CFG_IDX_W-1:0]  index;
    logic [tmef_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/temp_ma_ema_filter_with_trip_core.sv
// Thermocouple smoothing with heater trip.
//
// samples (sink): one word per reading, temp_sample in quarter degrees and
//   sensor_fault. ready is high only while the core is idle.
// results (source): mean_temp and filtered_temp in 1/1024 degree, shutoff and
//   shutoff_cause. Held in an output register until taken.
// cfg (sink): register writes, always ready; index 0 ema_alpha, 1 low trip
//   limit, 2 high trip limit, other indexes ignored. Write only while idle.
//
// Each word runs through a sequencer: ring update, a restoring divider that
// produces one quotient bit per cycle over SUM_W+8 bits (SUM_W is the running
// sum width, 15 for WINDOW = 7), then a bit-serial multiply by ema_alpha, one
// alpha bit per cycle over the 16 alpha bits. The multiply is skipped on a
// sensor fault or while the filter is uninitialised. A new word is taken in
// the idle state that follows loading of the previous result, so the core
// works on one word at a time. When results stalls, the finished word waits
// in the output register and the next word still runs; the core holds only
// once a second result is ready. Reset clears the ring fill state, the
// running sum and the filter, and loads the configuration defaults; the ring
// RAM is not cleared.
module temp_ma_ema_filter_with_trip_core #(
    parameter int WINDOW = 7
) (
    input  logic    clk,
    input  logic    rst_n,
    tmef_in_if.sink     samples,
    tmef_out_if.source  results,
    tmef_cfg_if.sink    cfg
);

    localparam int TEMP_W  = tmef_pkg::TEMP_W;
    localparam int OUT_W   = tmef_pkg::OUT_W;
    localparam int ALPHA_W = tmef_pkg::ALPHA_W;
    localparam int MCNT_W  = tmef_pkg::MCNT_W;
    localparam int SUM_MAX = WINDOW * (2 ** TEMP_W - 1);
    localparam int SUM_W   = $clog2(SUM_MAX + 1);
    localparam int CNT_W   = $clog2(WINDOW + 1);
    localparam int IDX_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int DW      = SUM_W + tmef_pkg::FRAC_BITS;
    localparam int DCNT_W  = $clog2(DW);
    localparam int D_W     = OUT_W + 1;
    localparam int ACC_W   = OUT_W + 2;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOAD   = 3'd1;
    localparam logic [2:0] S_SETUP  = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_MSETUP = 3'd4;
    localparam logic [2:0] S_MUL    = 3'd5;
    localparam logic [2:0] S_FIN    = 3'd6;
    localparam logic [2:0] S_OUT    = 3'd7;

    // ring storage
    logic [TEMP_W-1:0] ring_mem [WINDOW];
    logic [TEMP_W-1:0] rd_reg;
    logic              ring_we;

    logic [2:0]  state_reg, state_next;

    logic [ALPHA_W-1:0] alpha_reg, alpha_next;
    logic [TEMP_W-1:0]  min_reg, min_next;
    logic [TEMP_W-1:0]  max_reg, max_next;

    logic [TEMP_W-1:0]  sample_reg, sample_next;
    logic               fault_reg, fault_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [IDX_W-1:0]   widx_reg, widx_next;
    logic               full_reg, full_next;
    logic [OUT_W-1:0]   ema_reg, ema_next;

    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic [DW-1:0]      dq_reg, dq_next;
    logic [DCNT_W-1:0]  dcnt_reg, dcnt_next;
    logic [OUT_W-1:0]   mean_reg, mean_next;

    logic signed [D_W-1:0]   d_reg, d_next;
    logic signed [ACC_W-1:0] hi_reg, hi_next;
    logic                    lo_reg, lo_next;
    logic [ALPHA_W-1:0]      ash_reg, ash_next;
    logic [MCNT_W-1:0]       mcnt_reg, mcnt_next;
    logic                    skip_reg, skip_next;

    logic                      out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]          out_mean_reg, out_mean_next;
    logic [OUT_W-1:0]          out_filt_reg, out_filt_next;
    logic [tmef_pkg::CAUSE_W-1:0] out_cause_reg, out_cause_next;

    // datapath helpers
    logic [TEMP_W-1:0]       old_sample;
    logic [CNT_W:0]          trial;
    logic                    ge;
    logic [CNT_W:0]          trial_sub;
    logic [OUT_W-1:0]        quot;
    logic signed [ACC_W-1:0] mul_sum;
    logic signed [ACC_W-1:0] ema_ext;
    logic signed [ACC_W-1:0] lo_ext;
    logic signed [ACC_W-1:0] ema_tot;
    logic [OUT_W-1:0]        ema_clamped;
    logic                    out_free;

    assign samples.ready         = (state_reg == S_IDLE);
    assign cfg.ready             = 1'b1;
    assign results.valid         = out_valid_reg;
    assign results.mean_temp     = out_mean_reg;
    assign results.filtered_temp = out_filt_reg;
    assign results.shutoff_cause = out_cause_reg;
    assign results.shutoff       = (out_cause_reg != tmef_pkg::CAUSE_NONE);

    assign out_free = !out_valid_reg || results.ready;
    assign ring_we  = (state_reg == S_LOAD) && !fault_reg;

    // slots past the fill point were never written and read as zero
    assign old_sample = full_reg ? rd_reg : '0;

    // one restoring division step
    assign trial     = {rem_reg, dq_reg[DW-1]};
    assign ge        = (trial >= {1'b0, cnt_reg});
    assign trial_sub = trial - {1'b0, cnt_reg};
    assign quot      = (cnt_reg == '0) ? '0 : dq_reg[OUT_W-1:0];

    // one alpha bit of alpha * (mean - ema), shifted right each step
    assign mul_sum = hi_reg + (ash_reg[0] ? ACC_W'(d_reg) : ACC_W'(0));

    assign ema_ext = signed'({2'b00, ema_reg});
    assign lo_ext  = signed'({{(ACC_W-1){1'b0}}, lo_reg});
    assign ema_tot = ema_ext + hi_reg + lo_ext;

    always_comb
    begin
        if (ema_tot[ACC_W-1])
            ema_clamped = '0;
        else if (ema_tot[ACC_W-2:OUT_W] != '0)
            ema_clamped = tmef_pkg::OUT_MAX;
        else
            ema_clamped = ema_tot[OUT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ring_we)
            ring_mem[widx_reg] <= sample_reg;
        rd_reg <= ring_mem[widx_reg];
    end

    always_comb
    begin
        state_next     = state_reg;
        alpha_next     = alpha_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        sample_next    = sample_reg;
        fault_next     = fault_reg;
        sum_next       = sum_reg;
        widx_next      = widx_reg;
        full_next      = full_reg;
        ema_next       = ema_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        dq_next        = dq_reg;
        dcnt_next      = dcnt_reg;
        mean_next      = mean_reg;
        d_next         = d_reg;
        hi_next        = hi_reg;
        lo_next        = lo_reg;
        ash_next       = ash_reg;
        mcnt_next      = mcnt_reg;
        skip_next      = skip_reg;
        out_valid_next = out_valid_reg;
        out_mean_next  = out_mean_reg;
        out_filt_next  = out_filt_reg;
        out_cause_next = out_cause_reg;

        if (cfg.valid)
        begin
            unique case (cfg.index)
                tmef_pkg::CFG_EMA_ALPHA: alpha_next = cfg.data[ALPHA_W-1:0];
                tmef_pkg::CFG_TRIP_LOW:  min_next   = cfg.data[TEMP_W-1:0];
                tmef_pkg::CFG_TRIP_HIGH: max_next   = cfg.data[TEMP_W-1:0];
                default: ;
            endcase
        end

        // drop the result word once taken
        if (out_valid_reg && results.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (samples.valid)
                begin
                    sample_next = samples.temp_sample;
                    fault_next  = samples.sensor_fault;
                    state_next  = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (!fault_reg)
                begin
                    sum_next = sum_reg - SUM_W'(old_sample) + SUM_W'(sample_reg);
                    if (widx_reg == IDX_W'(WINDOW - 1))
                    begin
                        widx_next = '0;
                        full_next = 1'b1;
                    end
                    else
                        widx_next = widx_reg + 1'b1;
                end
                state_next = S_SETUP;
            end
            S_SETUP:
            begin
                cnt_next  = full_reg ? CNT_W'(WINDOW) : CNT_W'(widx_reg);
                dq_next   = {sum_reg, {tmef_pkg::FRAC_BITS{1'b0}}}
                            + DW'(cnt_next >> 1);
                rem_next  = '0;
                dcnt_next = DCNT_W'(DW - 1);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                rem_next = ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
                dq_next  = {dq_reg[DW-2:0], ge};
                if (dcnt_reg == '0)
                    state_next = S_MSETUP;
                else
                    dcnt_next = dcnt_reg - 1'b1;
            end
            S_MSETUP:
            begin
                mean_next = quot;
                d_next    = signed'({1'b0, quot}) - signed'({1'b0, ema_reg});
                hi_next   = '0;
                lo_next   = 1'b0;
                ash_next  = alpha_reg;
                mcnt_next = MCNT_W'(ALPHA_W - 1);
                skip_next = fault_reg || (ema_reg == '0);
                state_next = (fault_reg || (ema_reg == '0)) ? S_FIN : S_MUL;
            end
            S_MUL:
            begin
                hi_next  = mul_sum >>> 1;
                lo_next  = mul_sum[0];
                ash_next = ash_reg >> 1;
                if (mcnt_reg == '0)
                    state_next = S_FIN;
                else
                    mcnt_next = mcnt_reg - 1'b1;
            end
            S_FIN:
            begin
                // uninitialised filter takes the mean as is
                if (!fault_reg)
                    ema_next = skip_reg ? mean_reg : ema_clamped;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_mean_next  = mean_reg;
                    out_filt_next  = ema_reg;
                    if (fault_reg)
                        out_cause_next = tmef_pkg::CAUSE_FAULT;
                    else if (sample_reg < min_reg)
                        out_cause_next = tmef_pkg::CAUSE_LOW;
                    else if (ema_reg > {max_reg, {tmef_pkg::FRAC_BITS{1'b0}}})
                        out_cause_next = tmef_pkg::CAUSE_HIGH;
                    else
                        out_cause_next = tmef_pkg::CAUSE_NONE;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            alpha_reg     <= tmef_pkg::EMA_ALPHA_RST;
            min_reg       <= tmef_pkg::TRIP_LOW_RST;
            max_reg       <= tmef_pkg::TRIP_HIGH_RST;
            sum_reg       <= '0;
            widx_reg      <= '0;
            full_reg      <= 1'b0;
            ema_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            alpha_reg     <= alpha_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            sum_reg       <= sum_next;
            widx_reg      <= widx_next;
            full_reg      <= full_next;
            ema_reg       <= ema_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg    <= sample_next;
        fault_reg     <= fault_next;
        cnt_reg       <= cnt_next;
        rem_reg       <= rem_next;
        dq_reg        <= dq_next;
        dcnt_reg      <= dcnt_next;
        mean_reg      <= mean_next;
        d_reg         <= d_next;
        hi_reg        <= hi_next;
        lo_reg        <= lo_next;
        ash_reg       <= ash_next;
        mcnt_reg      <= mcnt_next;
        skip_reg      <= skip_next;
        out_mean_reg  <= out_mean_next;
        out_filt_reg  <= out_filt_next;
        out_cause_reg <= out_cause_next;
    end

    a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sum_reg <= SUM_W'(SUM_MAX))
        else $error("running sum exceeds ring capacity");

    a_widx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        widx_reg <= IDX_W'(WINDOW - 1))
        else $error("write index past end of ring");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && cnt_reg != '0) |-> (rem_reg < cnt_reg))
        else $error("divider remainder not below divisor");

    a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
        (samples.valid && samples.ready) |=> (state_reg == S_LOAD))
        else $error("accepted word did not start the ring update");

endmodule
